FILE: rtl/sha1md_pkg.sv
package sha1md_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned NUM_H    = 5;
    localparam int unsigned BLK_WORDS = 16;
    localparam int unsigned ROUNDS   = 80;
    localparam int unsigned RND_W    = $clog2(ROUNDS);
    localparam int unsigned POS_W    = $clog2(BLK_WORDS);
    localparam int unsigned CNT_W    = 61;
    localparam int unsigned NB_W     = 3;
    localparam int unsigned IDX_W    = 3;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [NUM_H-1:0][WORD_W-1:0] t_words5;

    localparam t_word H0 = 32'h67452301;
    localparam t_word H1 = 32'hEFCDAB89;
    localparam t_word H2 = 32'h98BADCFE;
    localparam t_word H3 = 32'h10325476;
    localparam t_word H4 = 32'hC3D2E1F0;

    localparam t_word K0 = 32'h5A827999;
    localparam t_word K1 = 32'h6ED9EBA1;
    localparam t_word K2 = 32'h8F1BBCDC;
    localparam t_word K3 = 32'hCA62C1D6;

    localparam t_word PAD_FULL = 32'h80000000;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [NB_W-1:0] NB_NONE  = 3'd0;
    localparam logic [NB_W-1:0] NB_ONE   = 3'd1;
    localparam logic [NB_W-1:0] NB_TWO   = 3'd2;
    localparam logic [NB_W-1:0] NB_THREE = 3'd3;
    localparam logic [NB_W-1:0] NB_FULL  = 3'd4;

    localparam logic [IDX_W-1:0] IDX_LAST = 3'd4;

    // working variables of one compression
    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
    } t_abcde;

    // commands from the sequencer to the compression core
    typedef struct packed {
        logic push;
        logic start;
        logic init;
    } t_core_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_stat;

    function automatic t_words5 h_init();
        t_words5 h;
        h[0] = H0;
        h[1] = H1;
        h[2] = H2;
        h[3] = H3;
        h[4] = H4;
        return h;
    endfunction

    // keep the valid top bytes of a partial final word and append the 0x80 marker
    function automatic t_word pad_word(input t_word w, input logic [NB_W-1:0] n);
        t_word p;
        case (n)
            NB_ONE:   p = {w[31:24], PAD_BYTE, 16'h0000};
            NB_TWO:   p = {w[31:16], PAD_BYTE, 8'h00};
            NB_THREE: p = {w[31:8], PAD_BYTE};
            default:  p = PAD_FULL;
        endcase
        return p;
    endfunction

endpackage

FILE: rtl/sha1md_round.sv
module sha1md_round (
    input  sha1md_pkg::t_abcde                    i_v,
    input  sha1md_pkg::t_word                     i_w,
    input  logic [sha1md_pkg::RND_W-1:0]          i_rnd,
    output sha1md_pkg::t_abcde                    o_v
);

    sha1md_pkg::t_word w_f;
    sha1md_pkg::t_word w_k;

    // pick the round function and constant by round group
    always_comb begin
        if (i_rnd < sha1md_pkg::RND_W'(20)) begin
            w_f = (i_v.b & i_v.c) | (~i_v.b & i_v.d);
            w_k = sha1md_pkg::K0;
        end else if (i_rnd < sha1md_pkg::RND_W'(40)) begin
            w_f = i_v.b ^ i_v.c ^ i_v.d;
            w_k = sha1md_pkg::K1;
        end else if (i_rnd < sha1md_pkg::RND_W'(60)) begin
            w_f = (i_v.b & i_v.c) | (i_v.b & i_v.d) | (i_v.c & i_v.d);
            w_k = sha1md_pkg::K2;
        end else begin
            w_f = i_v.b ^ i_v.c ^ i_v.d;
            w_k = sha1md_pkg::K3;
        end
    end

    // one round: new a from the five-term sum, rotate the rest down
    always_comb begin
        o_v.a = {i_v.a[26:0], i_v.a[31:27]} + w_f + i_v.e + w_k + i_w;
        o_v.b = i_v.a;
        o_v.c = {i_v.b[1:0], i_v.b[31:2]};
        o_v.d = i_v.c;
        o_v.e = i_v.d;
    end

endmodule

FILE: rtl/sha1md_core.sv
module sha1md_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sha1md_pkg::t_core_ctl i_ctl,
    input  sha1md_pkg::t_word     i_word,
    output sha1md_pkg::t_core_stat o_stat,
    output sha1md_pkg::t_words5   o_chain
);

    sha1md_pkg::t_words5                         r_h;
    logic [sha1md_pkg::BLK_WORDS-1:0][31:0]      r_w;
    sha1md_pkg::t_abcde                          r_v;
    logic [sha1md_pkg::RND_W-1:0]                r_rnd;
    logic                                        r_busy;
    logic                                        r_fin;

    sha1md_pkg::t_abcde w_v_next;
    sha1md_pkg::t_word  w_sched;

    sha1md_round u_round (
        .i_v   (r_v),
        .i_w   (r_w[0]),
        .i_rnd (r_rnd),
        .o_v   (w_v_next)
    );

    // next schedule word enters at the top as the oldest leaves
    assign w_sched = {r_w[13][30:0] ^ r_w[8][30:0] ^ r_w[2][30:0] ^ r_w[0][30:0],
                      r_w[13][31] ^ r_w[8][31] ^ r_w[2][31] ^ r_w[0][31]};

    // round counter, chaining words and final add
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_rnd  <= '0;
            r_h    <= sha1md_pkg::h_init();
        end else begin
            r_fin <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 1'b1;
                if (r_rnd == sha1md_pkg::RND_W'(sha1md_pkg::ROUNDS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
            if (i_ctl.init) begin
                r_h <= sha1md_pkg::h_init();
            end else if (r_fin) begin
                r_h[0] <= r_h[0] + r_v.a;
                r_h[1] <= r_h[1] + r_v.b;
                r_h[2] <= r_h[2] + r_v.c;
                r_h[3] <= r_h[3] + r_v.d;
                r_h[4] <= r_h[4] + r_v.e;
            end
        end
    end

    // working variables and the block buffer, which doubles as the schedule window
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_v <= '{a: r_h[0], b: r_h[1], c: r_h[2], d: r_h[3], e: r_h[4]};
        end else if (r_busy) begin
            r_v <= w_v_next;
        end
        if (i_ctl.push) begin
            r_w <= {i_word, r_w[sha1md_pkg::BLK_WORDS-1:1]};
        end else if (r_busy) begin
            r_w <= {w_sched, r_w[sha1md_pkg::BLK_WORDS-1:1]};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_fin;
    assign o_chain     = r_h;

`ifndef ASSERT_OFF
    // a word may only enter the buffer while no compression runs
    a_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.push |-> !r_busy || i_ctl.start)
        else $error("word pushed during compression");

    // the final add follows the last round directly
    a_fin_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> $past(r_busy))
        else $error("final add without a preceding round");
`endif

endmodule

FILE: rtl/sha1_message_digest.sv
// A non-final item is pushed into the block buffer as it is accepted; one that completes a
// 16-word block then waits for the compression core (80 rounds on one shared round unit plus
// the chaining add). A final item is followed by pushes of the word itself when full, the
// padding word, zeros up to position 14 and the two length words, with one compression per
// filled block (one or two); then the digest is loaded into an output register, from which
// the five digest items follow. No item is accepted while padding or a compression runs.
// Reset: i_rst_n synchronous active low; chaining words return to the initial values.
module sha1_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] message_word
    input  logic [2:0]  i_s_tuser,   // [2:0] valid_bytes
    input  logic        i_s_tlast,   // final_word
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] digest_word
    output logic [2:0]  o_m_tuser,   // [2:0] digest_index
    output logic        o_m_tlast    // digest_last
);

    typedef enum logic [2:0] {
        S_IDLE, S_WORD, S_PAD, S_ZERO, S_LHI, S_LLO, S_COMP, S_DONE
    } t_state;

    t_state                               r_state, n_state;
    t_state                               r_ret, n_ret;
    logic [sha1md_pkg::POS_W-1:0]         r_pos, n_pos;
    logic [sha1md_pkg::CNT_W-1:0]         r_cnt, n_cnt;
    sha1md_pkg::t_word                    r_word, n_word;
    sha1md_pkg::t_word                    r_pad, n_pad;
    sha1md_pkg::t_words5                  r_dig, n_dig;
    logic [sha1md_pkg::IDX_W-1:0]         r_oidx, n_oidx;
    logic                                 r_ovalid, n_ovalid;

    sha1md_pkg::t_core_ctl                w_ctl;
    sha1md_pkg::t_core_stat               w_stat;
    sha1md_pkg::t_words5                  w_chain;
    sha1md_pkg::t_word                    w_push_data;
    logic                                 w_push;
    t_state                               w_after;
    logic [sha1md_pkg::NB_W-1:0]          w_nb;
    logic                                 w_in_acc;
    logic                                 w_out_acc;

    sha1md_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_word  (w_push_data),
        .o_stat  (w_stat),
        .o_chain (w_chain)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_acc  = r_ovalid && i_m_tready;
    assign w_nb       = (i_s_tuser > sha1md_pkg::NB_FULL) ? sha1md_pkg::NB_FULL : i_s_tuser;

    // sequencer: buffer words, pad the message, run compressions, hand off the digest
    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_word      = r_word;
        n_pad       = r_pad;
        n_dig       = r_dig;
        n_oidx      = r_oidx;
        n_ovalid    = r_ovalid;
        w_ctl       = '0;
        w_push      = 1'b0;
        w_push_data = r_word;
        w_after     = r_state;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (!i_s_tlast) begin
                        n_cnt       = r_cnt + sha1md_pkg::CNT_W'(4);
                        w_push      = 1'b1;
                        w_push_data = i_s_tdata;
                        w_after     = S_IDLE;
                    end else begin
                        n_cnt   = r_cnt + sha1md_pkg::CNT_W'(w_nb);
                        n_word  = i_s_tdata;
                        n_pad   = sha1md_pkg::pad_word(i_s_tdata, w_nb);
                        n_state = (w_nb == sha1md_pkg::NB_FULL) ? S_WORD : S_PAD;
                    end
                end
            end
            S_WORD: begin
                w_push      = 1'b1;
                w_push_data = r_word;
                w_after     = S_PAD;
            end
            S_PAD: begin
                w_push      = 1'b1;
                w_push_data = r_pad;
                w_after     = S_ZERO;
            end
            S_ZERO: begin
                if (r_pos == sha1md_pkg::POS_W'(14)) begin
                    n_state = S_LHI;
                end else begin
                    w_push      = 1'b1;
                    w_push_data = '0;
                    w_after     = S_ZERO;
                end
            end
            S_LHI: begin
                w_push      = 1'b1;
                w_push_data = r_cnt[60:29];
                w_after     = S_LLO;
            end
            S_LLO: begin
                w_push      = 1'b1;
                w_push_data = {r_cnt[28:0], 3'b000};
                w_after     = S_DONE;
            end
            S_COMP: begin
                if (w_stat.done) begin
                    n_state = r_ret;
                end
            end
            S_DONE: begin
                if (!r_ovalid) begin
                    n_dig      = w_chain;
                    n_oidx     = '0;
                    n_ovalid   = 1'b1;
                    n_cnt      = '0;
                    w_ctl.init = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // every pushed word advances the position; the sixteenth starts a compression
        if (w_push) begin
            w_ctl.push = 1'b1;
            n_pos      = r_pos + 1'b1;
            if (r_pos == sha1md_pkg::POS_W'(sha1md_pkg::BLK_WORDS - 1)) begin
                w_ctl.start = 1'b1;
                n_ret       = w_after;
                n_state     = S_COMP;
            end else begin
                n_state = w_after;
            end
        end

        // drain the digest one item at a time
        if (w_out_acc) begin
            n_dig  = {sha1md_pkg::t_word'(0), r_dig[sha1md_pkg::NUM_H-1:1]};
            n_oidx = r_oidx + 1'b1;
            if (r_oidx == sha1md_pkg::IDX_LAST) begin
                n_ovalid = 1'b0;
            end
        end
    end

    // hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_pos    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_oidx   <= '0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_pos    <= n_pos;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
            r_oidx   <= n_oidx;
        end
        r_word <= n_word;
        r_pad  <= n_pad;
        r_dig  <= n_dig;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_dig[0];
    assign o_m_tuser  = r_oidx;
    assign o_m_tlast  = (r_oidx == sha1md_pkg::IDX_LAST);

`ifndef ASSERT_OFF
    // the core reports completion only while the sequencer waits for it
    a_done_in_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> r_state == S_COMP)
        else $error("compression done outside wait state");

    // the length words always land at the end of a block
    a_len_hi_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LHI |-> r_pos == sha1md_pkg::POS_W'(14))
        else $error("length word misplaced");

    // the last digest item closes the output burst
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> !o_m_tvalid)
        else $error("output still valid after last digest item");

    // a new digest is loaded only after the previous one has drained
    a_load_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.init |-> !r_ovalid)
        else $error("digest overwritten before drained");
`endif

endmodule

FILE: bench/sha1_message_digest_test.sv
module sha1_message_digest_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_ITEMS  = 400;
    localparam int DRAIN_CYCLES  = 300;
    localparam int MAX_REPORTS   = 10;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [31:0] IV_E = 32'hC3D2E1F0;

    localparam logic [31:0] RC_CH  = 32'h5A827999;
    localparam logic [31:0] RC_PA1 = 32'h6ED9EBA1;
    localparam logic [31:0] RC_MAJ = 32'h8F1BBCDC;
    localparam logic [31:0] RC_PA2 = 32'hCA62C1D6;

    localparam logic [31:0] PAD_MARK = 32'h8000_0000;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    // one message item as driven on the input stream
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        fin;
    } t_msg_item;

    // one digest word as seen on the output stream
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_item;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata  = '0;   // [31:0] message_word
    logic [2:0]  i_s_tuser  = '0;   // [2:0] valid_bytes
    logic        i_s_tlast  = 1'b0; // final_word
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;         // [31:0] digest_word
    logic [2:0]  o_m_tuser;         // [2:0] digest_index
    logic        o_m_tlast;         // digest_last

    sha1_message_digest uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    t_msg_item    message_items[$];
    t_digest_item pending_digest[$];

    // hash state tracked alongside the block
    logic [31:0] chain_h[5];
    logic [31:0] blk_words[16];
    logic [3:0]  blk_pos;
    logic [60:0] msg_bytes;

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  item_count     = 0;
    int  in_gap         = 0;
    int  out_hold       = 0;
    bit  in_calm        = 1'b0;
    bit  out_calm       = 1'b0;
    logic in_fire       = 1'b0;
    logic out_fire      = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void restart_hash();
        chain_h[0] = IV_A;
        chain_h[1] = IV_B;
        chain_h[2] = IV_C;
        chain_h[3] = IV_D;
        chain_h[4] = IV_E;
        blk_pos    = '0;
        msg_bytes  = '0;
    endfunction

    // run the 80 rounds over the buffered block and fold into the chain
    function automatic void sha1_compress();
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int r = 0; r < 16; r++) w[r] = blk_words[r];
        for (int r = 16; r < 80; r++) begin
            w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = RC_CH;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = RC_PA1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = RC_MAJ;
            end else begin
                f = b ^ c ^ d;
                k = RC_PA2;
            end
            t = rotl(a, 5) + f + e + k + w[r];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    function automatic void sha1_absorb(input logic [31:0] w);
        blk_words[blk_pos] = w;
        blk_pos = blk_pos + 4'd1;
        if (blk_pos == 4'd0) sha1_compress();
    endfunction

    // advance the hash by one accepted item; a final item queues the digest
    function automatic void sha1_take_item(input t_msg_item it);
        int          n;
        logic [31:0] pad;
        logic [63:0] bits;
        if (!it.fin) begin
            msg_bytes = msg_bytes + 61'd4;
            sha1_absorb(it.word);
        end else begin
            n = (it.nbytes > sha1md_pkg::NB_FULL) ? int'(sha1md_pkg::NB_FULL)
                                                   : int'(it.nbytes);
            msg_bytes = msg_bytes + 61'(n);
            if (n == int'(sha1md_pkg::NB_FULL)) begin
                sha1_absorb(it.word);
                pad = PAD_MARK;
            end else if (n == int'(sha1md_pkg::NB_NONE)) begin
                pad = PAD_MARK;
            end else begin
                pad = (it.word & (ALL_ONES << (32 - 8 * n))) | (32'h80 << (24 - 8 * n));
            end
            sha1_absorb(pad);
            if (blk_pos == 4'd15) sha1_absorb('0);
            while (blk_pos < 4'd14) sha1_absorb('0);
            bits = {msg_bytes, 3'b000};
            sha1_absorb(bits[63:32]);
            sha1_absorb(bits[31:0]);
            for (int i = 0; i < 5; i++) begin
                pending_digest.push_back(t_digest_item'{chain_h[i], 3'(i),
                                                       3'(i) == sha1md_pkg::IDX_LAST});
            end
            restart_hash();
        end
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
    endfunction

    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return '0;
        if (r == 1) return ALL_ONES;
        return $urandom;
    endfunction

    function automatic void add_item(input logic [31:0] w, input logic [2:0] nb, input logic fin);
        message_items.push_back(t_msg_item'{w, nb, fin});
        item_count++;
    endfunction

    // full words (with random byte counts when noisy), then a final word with a random byte count
    function automatic void add_message(input int nwords, input bit noisy);
        for (int i = 0; i < nwords; i++) begin
            add_item(pick_word(), noisy ? 3'($urandom_range(0, 7)) : sha1md_pkg::NB_FULL, 1'b0);
        end
        add_item(pick_word(), 3'($urandom_range(0, 7)), 1'b1);
    endfunction

    // sample both handshakes; score outputs before predicting new inputs
    always @(posedge i_clk) begin
        t_digest_item got;
        t_digest_item want;
        in_fire  <= i_rst_n && i_s_tvalid && o_s_tready;
        out_fire <= i_rst_n && o_m_tvalid && i_m_tready;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_digest_item'{o_m_tdata, o_m_tuser, o_m_tlast};
            if (pending_digest.size() == 0) begin
                note_mismatch($sformatf("unexpected item word=%h index=%0d last=%b",
                                        got.word, got.index, got.last));
            end else begin
                want = pending_digest.pop_front();
                if (got.word !== want.word || got.index !== want.index
                        || got.last !== want.last) begin
                    note_mismatch($sformatf({"digest mismatch: expected word=%h index=%0d",
                                             " last=%b, got word=%h index=%0d last=%b"},
                                            want.word, want.index, want.last,
                                            got.word, got.index, got.last));
                end
            end
        end
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            sha1_take_item(t_msg_item'{i_s_tdata, i_s_tuser, i_s_tlast});
        end
    end

    // input stream: hold until taken, then wait out the drawn gap
    always @(negedge i_clk) begin
        t_msg_item cur;
        if (i_rst_n && !(i_s_tvalid && !in_fire)) begin
            if (in_gap > 0) begin
                in_gap--;
                i_s_tvalid <= 1'b0;
            end else if (message_items.size() > 0) begin
                cur = message_items.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= cur.word;
                i_s_tuser  <= cur.nbytes;
                i_s_tlast  <= cur.fin;
                if ($urandom_range(0, 19) == 0) in_calm = !in_calm;
                in_gap = in_calm ? 0 : $urandom_range(0, 15);
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // output stream: after each accepted item, drop ready for a randomly drawn stall
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_fire) begin
                if ($urandom_range(0, 19) == 0) out_calm = !out_calm;
                out_hold = out_calm ? 0 : $urandom_range(0, 15);
            end
            if (out_hold > 0) begin
                out_hold--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int len;
        int pick;
        restart_hash();

        // empty message, data bits ignored
        add_item(ALL_ONES, sha1md_pkg::NB_NONE, 1'b1);
        // three-byte message with junk in the unused low byte
        add_item(32'h616263FF, 3'd3, 1'b1);
        add_item(ALL_ONES, sha1md_pkg::NB_ONE, 1'b1);
        add_item('0, sha1md_pkg::NB_TWO, 1'b1);
        add_item('0, sha1md_pkg::NB_FULL, 1'b1);
        // byte counts above four saturate on the final word
        add_item(ALL_ONES, 3'd5, 1'b1);
        add_item(32'h0123_4567, 3'd6, 1'b1);
        add_item(ALL_ONES, 3'd7, 1'b1);
        // byte count ignored on a non-final word
        add_item(32'hDEAD_BEEF, sha1md_pkg::NB_NONE, 1'b0);
        add_item(ALL_ONES, sha1md_pkg::NB_FULL, 1'b1);
        // padding marker lands on word 14: length spills into an extra block
        for (int i = 0; i < 13; i++) add_item(i[0] ? ALL_ONES : '0, sha1md_pkg::NB_FULL, 1'b0);
        add_item(32'hA5A5_5A5A, sha1md_pkg::NB_FULL, 1'b1);

        // random messages, biased toward block-boundary lengths
        while (item_count < RANDOM_ITEMS + 24) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) len = $urandom_range(0, 20);
            else if (pick < 9) len = $urandom_range(12, 17);
            else len = $urandom_range(30, 80);
            add_message(len, $urandom_range(0, 7) == 0);
        end

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (message_items.size() != 0 || i_s_tvalid || pending_digest.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0 && pending_digest.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/sha1md_pkg.sv
rtl/sha1md_round.sv
rtl/sha1md_core.sv
rtl/sha1_message_digest.sv
bench/sha1_message_digest_test.sv
